[src/oms_pkg.sv]
// ----------------------------------------------------------------------------
// oms_pkg
// Types and constants for the overtaking maneuver sequencer.
// ----------------------------------------------------------------------------
package oms_pkg;

	localparam int TIME_BITS_DEF = 16;
	localparam int DIST_W        = 16;
	localparam int ANGLE_W       = 11;
	localparam int SPEED_W       = 3;
	localparam int NOW_W         = 16;

	typedef logic signed [DIST_W-1:0]  dist_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [SPEED_W-1:0] speed_t;

	typedef enum logic [2:0] {
		PH_FOLLOW       = 3'd0,
		PH_ENTER        = 3'd1,
		PH_PASS_START   = 3'd2,
		PH_CLEAR_WAIT   = 3'd3,
		PH_PARALLEL     = 3'd4,
		PH_RETURN_CHECK = 3'd5,
		PH_RIGHT_TURN   = 3'd6,
		PH_ALIGN        = 3'd7
	} phase_t;

	// distance thresholds, tenths
	localparam dist_t FRONT_MIN      = 16'sd9;
	localparam dist_t FRONT_MAX      = 16'sd90;
	localparam dist_t RIGHT_NEAR_MAX = 16'sd200;
	localparam dist_t BACK_NEAR_MAX  = 16'sd150;
	localparam dist_t FR_CLEAR_MIN   = 16'sd50;
	localparam dist_t FR_PARALLEL    = 16'sd30;
	localparam dist_t FR_NONE_LIMIT  = -16'sd10;
	localparam dist_t FAR_LIMIT      = 16'sd250;
	localparam dist_t SR_NEAR_MIN    = 16'sd10;
	localparam dist_t DIST_ZERO      = 16'sd0;

	// steering angles, tenths of a degree
	localparam angle_t ANG_ENTRY_OFS = -11'sd200;
	localparam angle_t ANG_STRAIGHT  = 11'sd0;
	localparam angle_t ANG_PASS      = 11'sd100;
	localparam angle_t ANG_HARD      = 11'sd250;
	localparam angle_t ANG_CORRECT   = 11'sd120;
	localparam angle_t ANG_NUDGE     = -11'sd10;
	localparam angle_t ANG_BACK      = -11'sd250;
	localparam angle_t ST_LANE_LIM   = 11'sd10;
	localparam angle_t ST_LANE_NEG   = -11'sd10;
	localparam angle_t ST_CURVE_MIN  = 11'sd130;

	localparam speed_t SPD_SLOW   = 3'sd1;
	localparam speed_t SPD_CRUISE = 3'sd2;

	// elapsed-time limits, whole seconds
	localparam int TM_MIN_1S    = 1;
	localparam int TM_CLEAR     = 2;
	localparam int TM_ALIGN_MIN = 2;
	localparam int TM_ALIGN_MAX = 3;
	localparam int TM_TURN_MAX  = 4;

endpackage

[src/overtake_maneuver_sequencer_core.sv]
// ----------------------------------------------------------------------------
// overtake_maneuver_sequencer_core
// Lane follow / overtaking phase sequencer, one command word per sensor word.
// ----------------------------------------------------------------------------
// Takes one sensor word per clock while item_stall is low and returns one
// command word per sensor word, in order. A word is captured in an input
// register and the phase step (a handful of compares and a mux) runs between
// that register and the phase and held-command registers, which drive the
// result port directly. Result valid rises when the word leaves the input
// register into the phase and held-command registers; throughput is one
// word per clock as long as the result side does not stall. Elapsed time
// uses the low TIME_BITS bits of now_seconds.
module overtake_maneuver_sequencer_core #(
	parameter int TIME_BITS = oms_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  oms_pkg::dist_t       sonar_front,
	input  oms_pkg::dist_t       sonar_right,
	input  oms_pkg::dist_t       ir_front_right,
	input  oms_pkg::dist_t       ir_back_right,
	input  oms_pkg::angle_t      lane_steer,
	input  oms_pkg::speed_t      lane_speed,
	input  logic [15:0]          now_seconds,
	output logic                 result_valid,
	input  logic                 result_stall,
	output oms_pkg::angle_t      steer_cmd,
	output oms_pkg::speed_t      speed_cmd,
	output logic [2:0]           phase
);
	import oms_pkg::*;

	localparam int NOW_EXT = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

	// input stage
	logic        s1_valid;
	dist_t       sonar_front_s1, sonar_right_s1, ir_front_right_s1, ir_back_right_s1;
	angle_t      lane_steer_s1;
	speed_t      lane_speed_s1;
	logic [15:0] now_s1;

	// state
	phase_t                 phase_q, phase_n;
	logic [TIME_BITS-1:0]   mark_q, mark_n;
	dist_t                  last_fr_q, last_fr_n;
	logic                   no_lane_q, no_lane_n;
	angle_t                 held_angle_q, held_angle_n;
	speed_t                 held_speed_q, held_speed_n;
	logic                   result_valid_q;

	logic                   adv;
	logic                   follow;
	logic [NOW_EXT-1:0]     now_ext;
	logic [TIME_BITS-1:0]   now_t;
	logic [TIME_BITS-1:0]   elapsed;

	assign adv        = s1_valid && (!result_valid_q || !result_stall);
	assign item_stall = s1_valid && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!item_stall) begin
			s1_valid <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			sonar_front_s1    <= sonar_front;
			sonar_right_s1    <= sonar_right;
			ir_front_right_s1 <= ir_front_right;
			ir_back_right_s1  <= ir_back_right;
			lane_steer_s1     <= lane_steer;
			lane_speed_s1     <= lane_speed;
			now_s1            <= now_seconds;
		end
	end

	assign now_ext = NOW_EXT'(now_s1);
	assign now_t   = now_ext[TIME_BITS-1:0];
	assign elapsed = now_t - mark_q;

	assign follow = (phase_q == PH_FOLLOW) &&
		(sonar_front_s1 < FRONT_MIN || sonar_front_s1 > FRONT_MAX);

	always_comb begin
		phase_n      = phase_q;
		mark_n       = mark_q;
		last_fr_n    = last_fr_q;
		no_lane_n    = no_lane_q;
		held_angle_n = held_angle_q;
		held_speed_n = held_speed_q;
		if (follow) begin
			held_angle_n = lane_steer_s1;
			held_speed_n = lane_speed_s1;
		end else begin
			unique case (phase_q)
				PH_FOLLOW: begin
					phase_n      = PH_ENTER;
					held_angle_n = ANG_ENTRY_OFS + (lane_steer_s1 >>> 1);
					held_speed_n = SPD_SLOW;
					mark_n       = now_t;
				end
				PH_ENTER: begin
					if (!(sonar_right_s1 < DIST_ZERO || sonar_right_s1 > RIGHT_NEAR_MAX)) begin
						held_angle_n = ANG_STRAIGHT;
						held_speed_n = SPD_CRUISE;
						phase_n      = PH_PASS_START;
					end
				end
				PH_PASS_START: begin
					if (!(ir_back_right_s1 < DIST_ZERO || ir_back_right_s1 > BACK_NEAR_MAX)) begin
						held_angle_n = ANG_PASS;
						mark_n       = now_t;
						phase_n      = PH_CLEAR_WAIT;
					end
				end
				PH_CLEAR_WAIT: begin
					if (!(elapsed < TIME_BITS'(TM_CLEAR) && ir_front_right_s1 > FR_CLEAR_MIN)) begin
						held_angle_n = ANG_STRAIGHT;
						phase_n      = PH_PARALLEL;
					end
				end
				PH_PARALLEL: begin
					held_speed_n = SPD_CRUISE;
					held_angle_n = ANG_STRAIGHT;
					mark_n       = now_t;
					if (last_fr_q < ir_front_right_s1)
						held_angle_n = ANG_HARD;
					else if (ir_front_right_s1 > ir_back_right_s1)
						held_angle_n = ANG_CORRECT;
					else
						phase_n = PH_RETURN_CHECK;
					if (ir_front_right_s1 < DIST_ZERO || ir_front_right_s1 > FR_PARALLEL)
						phase_n = PH_RETURN_CHECK;
				end
				PH_RETURN_CHECK: begin
					held_angle_n = ANG_NUDGE;
					if (!(elapsed < TIME_BITS'(TM_MIN_1S) ||
						(ir_front_right_s1 > FR_NONE_LIMIT && ir_back_right_s1 < DIST_ZERO) ||
						(ir_front_right_s1 > FR_NONE_LIMIT && ir_front_right_s1 < FAR_LIMIT) ||
						(sonar_right_s1 > SR_NEAR_MIN && sonar_right_s1 < FAR_LIMIT))) begin
						phase_n      = PH_RIGHT_TURN;
						held_angle_n = ANG_HARD;
						mark_n       = now_t;
					end
				end
				PH_RIGHT_TURN: begin
					if (!(elapsed < TIME_BITS'(TM_TURN_MAX) && (elapsed < TIME_BITS'(TM_MIN_1S) ||
						lane_steer_s1 < ST_CURVE_MIN || no_lane_q))) begin
						held_angle_n = ANG_BACK;
						phase_n      = PH_ALIGN;
						mark_n       = now_t;
					end
				end
				PH_ALIGN: begin
					if (!(elapsed < TIME_BITS'(TM_ALIGN_MAX) && (elapsed < TIME_BITS'(TM_ALIGN_MIN) ||
						lane_steer_s1 < ST_LANE_LIM || no_lane_q))) begin
						phase_n = PH_FOLLOW;
					end
				end
			endcase
			last_fr_n = ir_front_right_s1;
			no_lane_n = (lane_steer_s1 < ST_LANE_LIM) && (lane_steer_s1 > ST_LANE_NEG);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FOLLOW;
			mark_q         <= '0;
			last_fr_q      <= '0;
			no_lane_q      <= 1'b1;
			held_angle_q   <= ANG_STRAIGHT;
			held_speed_q   <= SPD_CRUISE;
			result_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q      <= phase_n;
				mark_q       <= mark_n;
				last_fr_q    <= last_fr_n;
				no_lane_q    <= no_lane_n;
				held_angle_q <= held_angle_n;
				held_speed_q <= held_speed_n;
			end
			if (adv)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign steer_cmd    = held_angle_q;
	assign speed_cmd    = held_speed_q;
	assign phase        = phase_q;

	// state only moves when a word is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(held_angle_q) && $stable(mark_q))
		else $error("state changed without a processed word");

	// phase steps forward by at most one, or wraps from align back to follow
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (phase_q == $past(phase_q)) ||
			(phase_q == 3'($past(phase_q) + 3'd1)) ||
			(phase_q == PH_FOLLOW && $past(phase_q) == PH_ALIGN))
		else $error("illegal phase transition");

	// in follow mode the lane follower proposal passes straight through
	a_follow_pass: assert property (@(posedge clk) disable iff (!arst_n)
		adv && follow |=> steer_cmd == $past(lane_steer_s1) &&
			speed_cmd == $past(lane_speed_s1) && phase_q == PH_FOLLOW)
		else $error("follow mode did not pass lane command");

endmodule
